// ===== rtl/sha1_pkg.sv =====
// SHA-1 engine package: request type, round constants, initial hash words.
// No dependencies.
package sha1_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       finish;
      logic       keep_state;
   } req_type;

   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;
   localparam logic [159:0] H_INIT =
      160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

endpackage

// ===== rtl/sha1_req_fifo.sv =====
// Two-entry request queue between the front (accept) and back (hash) parts.
// Depends on sha1_pkg.
module sha1_req_fifo
   import sha1_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  req_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output req_type rd_data,
   output logic    empty
);
   req_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign rd_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en && !full) mem_ff[wptr_ff] <= wr_data;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (wr_en && !full) wptr_ff <= ~wptr_ff;
         if (rd_en && !empty) rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + 2'((wr_en && !full) ? 1 : 0) - 2'((rd_en && !empty) ? 1 : 0);
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("fifo count out of range");
   a_nowr: assert property (@(posedge clock) disable iff (reset)
      full && !rd_en |=> full) else $error("fifo lost entry");
   a_cntstep: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !full && !(rd_en && !empty)) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("fifo count step");
endmodule

// ===== rtl/sha1_round.sv =====
// SHA-1 compression unit: one round per cycle, 16-word rolling schedule.
// Depends on sha1_pkg.
module sha1_round
   import sha1_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [511:0] block,
   input  logic [159:0] h_in,
   output logic         done,
   output logic [159:0] h_out
);
   logic [31:0]  w_ff [16];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [159:0] h_ff;
   logic [6:0]   rnd_ff;
   logic         busy_ff, done_ff;
   logic [31:0]  wi, f, k, t;

   always_comb begin
      if (rnd_ff < 7'd16) wi = w_ff[0];
      else wi = rotl1(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]);
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) ^ (~b_ff & d_ff); k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) ^ (b_ff & d_ff) ^ (c_ff & d_ff); k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + wi;
   end

   assign done  = done_ff;
   assign h_out = h_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= block[511-32*i -: 32];
         {a_ff, b_ff, c_ff, d_ff, e_ff} <= h_in;
         h_ff <= h_in;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wi;
         e_ff <= d_ff; d_ff <= c_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff; a_ff <= t;
      end else if (done_ff) begin
         h_ff <= {h_ff[159:128] + a_ff, h_ff[127:96] + b_ff, h_ff[95:64] + c_ff,
                  h_ff[63:32] + d_ff, h_ff[31:0] + e_ff};
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rnd_ff  <= 7'd0;
         end else if (busy_ff) begin
            rnd_ff <= rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
   // h_out is valid the cycle after done

   a_rnd: assert property (@(posedge clock) disable iff (reset) busy_ff |-> rnd_ff < 7'd80)
      else $error("round index out of range");
   a_done: assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("done while busy");
   a_end: assert property (@(posedge clock) disable iff (reset)
      busy_ff && rnd_ff == 7'd79 && !start |=> done_ff) else $error("missing done");
endmodule

// ===== rtl/sha1_back.sv =====
// Back end: absorbs bytes, pads on digest request, emits five words.
// Depends on sha1_pkg and sha1_round.
module sha1_back
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  req_type     q_data,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_length_overflow
);
   typedef enum logic [3:0] {
      S_IDLE, S_BLK, S_BLK_WAIT, S_BLK_SUM, S_FIN, S_P1_WAIT, S_P1_SUM,
      S_P2, S_P2_WAIT, S_P2_SUM, S_OUT
   } state_type;

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_PAD   = 2'd1;
   localparam logic [1:0] MODE_LEN   = 2'd2;

   state_type    state_ff;
   logic [7:0]   buf_ff [64];
   logic [159:0] cv_ff, hd_ff;
   logic [6:0]   fill_ff;
   logic [63:0]  bits_ff;
   logic         ovf_ff, dovf_ff, keep_ff, fin_ff;
   logic [2:0]   idx_ff;
   logic         start;
   logic [511:0] blk;
   logic         done;
   logic [159:0] h_in, h_out;
   logic [5:0]   pos;
   logic [63:0]  len_in;
   logic [1:0]   mode;  // block source: buffer, padded buffer, zeros plus length

   assign pos = fill_ff[5:0];
   assign len_in = bits_ff + {55'd0, pos, 3'd0};

   always_comb begin
      for (int i = 0; i < 64; i++) begin
         logic [7:0] b;
         b = buf_ff[i];
         if (mode != MODE_PLAIN) begin
            if (mode == MODE_LEN || i > pos) b = 8'h00;
            else if (i == pos) b = 8'h80;
            if (i >= 56 && (mode == MODE_LEN || pos < 6'd56)) b = len_in[63-8*(i-56) -: 8];
         end
         blk[511-8*i -: 8] = b;
      end
   end

   assign q_pop     = (state_ff == S_IDLE) && !q_empty;
   assign rsp_empty = state_ff != S_OUT;
   assign rsp_digest_word = hd_ff[159-32*idx_ff -: 32];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = idx_ff == 3'd4;
   assign rsp_length_overflow = dovf_ff;

   always_comb begin
      start = 1'b0; mode = MODE_PLAIN; h_in = cv_ff;
      unique case (state_ff)
         S_BLK: start = 1'b1;
         S_FIN: begin start = 1'b1; mode = MODE_PAD; end
         S_P2:  begin start = 1'b1; mode = MODE_LEN; h_in = hd_ff; end
         S_P1_WAIT, S_P1_SUM: mode = MODE_PAD;
         default: ;
      endcase
   end

   sha1_round u_round (.clock, .reset, .start, .block(blk), .h_in, .done, .h_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cv_ff <= H_INIT; fill_ff <= 7'd0; bits_ff <= 64'd0; ovf_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (!q_empty) begin
               fin_ff  <= q_data.finish;
               keep_ff <= q_data.keep_state;
               if (q_data.byte_valid) begin
                  buf_ff[pos] <= q_data.data_byte;
                  if (pos == 6'd63) begin
                     fill_ff <= 7'd0;
                     state_ff <= S_BLK;
                  end else begin
                     fill_ff <= fill_ff + 7'd1;
                     if (q_data.finish) state_ff <= S_FIN;
                  end
               end else if (q_data.finish) state_ff <= S_FIN;
            end
            S_BLK: state_ff <= S_BLK_WAIT;
            S_BLK_WAIT: if (done) state_ff <= S_BLK_SUM;
            S_BLK_SUM: begin
               cv_ff <= h_out;
               bits_ff <= bits_ff + 64'd512;
               if (bits_ff[63:9] == '1) ovf_ff <= 1'b1;
               state_ff <= fin_ff ? S_FIN : S_IDLE;
            end
            S_FIN: begin
               dovf_ff <= ovf_ff | (len_in < {55'd0, pos, 3'd0});
               state_ff <= S_P1_WAIT;
            end
            S_P1_WAIT: if (done) state_ff <= S_P1_SUM;
            S_P1_SUM: begin
               hd_ff <= h_out;
               state_ff <= (pos >= 6'd56) ? S_P2 : S_OUT;
               idx_ff <= 3'd0;
            end
            S_P2: state_ff <= S_P2_WAIT;
            S_P2_WAIT: if (done) state_ff <= S_P2_SUM;
            S_P2_SUM: begin hd_ff <= h_out; idx_ff <= 3'd0; state_ff <= S_OUT; end
            S_OUT: if (rsp_pop) begin
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  state_ff <= S_IDLE;
                  if (!keep_ff) begin
                     cv_ff <= H_INIT; fill_ff <= 7'd0; bits_ff <= 64'd0; ovf_ff <= 1'b0;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> idx_ff <= 3'd4) else $error("word index out of range");
   a_fill: assert property (@(posedge clock) disable iff (reset) fill_ff < 7'd64)
      else $error("fill count out of range");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_OUT) else $error("output while absorbing");
endmodule

// ===== rtl/sha1_hash_engine_core.sv =====
// SHA-1 engine top: request queue feeding the hashing back end.
// A byte is absorbed from the queue head while the back end is idle; a byte that
// fills a block adds setup, 80 rounds, done and sum before the next request.
// A digest request runs one or two padded blocks through the rounds, then five pops.
// Throughput is bound by the round unit; no request is taken while a block hashes.
// Synchronous active-high reset restores the SHA-1 initial hash state.
module sha1_hash_engine_core
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_finish,
   input  logic        req_keep_state,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_length_overflow
);
   req_type wr_data, rd_data;
   logic    q_empty, q_pop;

   assign wr_data = '{data_byte: req_data_byte, byte_valid: req_byte_valid,
                      finish: req_finish, keep_state: req_keep_state};

   sha1_req_fifo u_fifo (.clock, .reset, .wr_en(push), .wr_data, .full,
                         .rd_en(q_pop), .rd_data, .empty(q_empty));

   sha1_back u_back (.clock, .reset, .q_empty, .q_data(rd_data), .q_pop,
                     .rsp_empty(empty), .rsp_pop(pop), .rsp_digest_word,
                     .rsp_word_index, .rsp_last_word, .rsp_length_overflow);
endmodule
